// File: design/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is held
`define DLLM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dllm assertion failed");

// concurrent check that also covers the reset cycles
`define DLLM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dllm assertion failed during reset");

`endif

// File: design/dllm_pkg.sv
// types, constants and request codes of the linked list manager
// no dependencies
package dllm_pkg;

    localparam int NODES     = 256;
    localparam int ADDR_W    = $clog2(NODES);
    localparam int LEN_W     = $clog2(NODES + 1);
    localparam int NODE_W    = 8;
    localparam int COUNT_W   = 9;
    localparam int REQ_W     = 3;
    localparam int IN_DATA_W = ((NODE_W + 7) / 8) * 8;
    localparam int RES_W     = NODE_W + 1 + COUNT_W + 1;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INSERT_MID = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd5;

    // one port request for a link memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // result item, node_out in the lowest bits
    typedef struct packed {
        logic               is_empty;
        logic [COUNT_W-1:0] count;
        logic               error;
        logic [NODE_W-1:0]  node_out;
    } t_result;

endpackage

// File: design/dllm_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module dllm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/dllm_ctrl.sv
// request sequencer: head, tail and length registers, link memory accesses
// depends on dllm_pkg
module dllm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [dllm_pkg::REQ_W-1:0]    i_in_req,
    input  logic [dllm_pkg::NODE_W-1:0]   i_in_node,
    output logic                          o_in_ready,
    input  logic                          i_out_free,
    output logic                          o_res_valid,
    output dllm_pkg::t_result             o_res,
    output dllm_pkg::t_mem_req            o_next_req,
    output dllm_pkg::t_mem_req            o_prev_req,
    input  logic [dllm_pkg::ADDR_W-1:0]   i_next_rdata,
    input  logic [dllm_pkg::ADDR_W-1:0]   i_prev_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIXP = 3'd1;
    localparam logic [2:0] S_FIXN = 3'd2;
    localparam logic [2:0] S_POPF = 3'd3;
    localparam logic [2:0] S_POPB = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_LINK = 3'd6;
    localparam logic [2:0] S_RESP = 3'd7;

    localparam int AW = dllm_pkg::ADDR_W;
    localparam int LW = dllm_pkg::LEN_W;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_len, n_len;
    logic [AW-1:0] r_node, n_node;
    logic [AW-1:0] r_at, n_at;
    logic [AW-1:0] r_after, n_after;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_popped, n_popped;
    logic          r_err, n_err;

    logic          w_emit;
    logic          w_start;
    logic          w_len_zero;
    logic          w_can_ins;
    logic [AW-1:0] w_addr;
    dllm_pkg::t_mem_req w_next_req, w_prev_req;

    assign w_emit     = (r_state == S_RESP) && i_out_free;
    assign o_in_ready = (r_state == S_IDLE) || w_emit;
    assign w_start    = i_in_valid && o_in_ready;
    assign w_len_zero = (r_len == '0);
    assign w_addr     = AW'(i_in_node);
    assign w_can_ins  = (int'(r_len) < dllm_pkg::NODES) &&
                        (int'(i_in_node) < dllm_pkg::NODES);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_len      = r_len;
        n_node     = r_node;
        n_at       = r_at;
        n_after    = r_after;
        n_cnt      = r_cnt;
        n_popped   = r_popped;
        n_err      = r_err;
        w_next_req = '0;
        w_prev_req = '0;

        case (r_state)
            S_RESP: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            S_FIXP: begin
                // old head now points back at the new one
                w_prev_req.we    = 1'b1;
                w_prev_req.waddr = r_at;
                w_prev_req.wdata = r_node;
                n_state          = S_RESP;
            end
            S_FIXN: begin
                w_next_req.we    = 1'b1;
                w_next_req.waddr = r_at;
                w_next_req.wdata = r_node;
                n_state          = S_RESP;
            end
            S_POPF: begin
                n_head           = i_next_rdata;
                w_prev_req.we    = 1'b1;
                w_prev_req.waddr = i_next_rdata;
                w_prev_req.wdata = '0;
                n_state          = S_RESP;
            end
            S_POPB: begin
                n_tail           = i_prev_rdata;
                w_next_req.we    = 1'b1;
                w_next_req.waddr = i_prev_rdata;
                w_next_req.wdata = '0;
                n_state          = S_RESP;
            end
            S_WALK: begin
                if (r_cnt == '0) begin
                    // read data is the successor of the insert point
                    n_after          = i_next_rdata;
                    w_next_req.we    = 1'b1;
                    w_next_req.waddr = r_node;
                    w_next_req.wdata = i_next_rdata;
                    w_prev_req.we    = 1'b1;
                    w_prev_req.waddr = r_node;
                    w_prev_req.wdata = r_at;
                    n_state          = S_LINK;
                end else begin
                    n_at             = i_next_rdata;
                    w_next_req.raddr = i_next_rdata;
                    n_cnt            = r_cnt - LW'(1);
                end
            end
            S_LINK: begin
                w_next_req.we    = 1'b1;
                w_next_req.waddr = r_at;
                w_next_req.wdata = r_node;
                w_prev_req.we    = 1'b1;
                w_prev_req.waddr = r_after;
                w_prev_req.wdata = r_node;
                n_state          = S_RESP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new request starts only from idle or the response cycle,
        // neither of which touches the memories
        if (w_start) begin
            n_node   = w_addr;
            n_popped = '0;
            n_err    = 1'b0;
            n_state  = S_RESP;
            case (i_in_req)
                dllm_pkg::REQ_PUSH_FRONT: begin
                    if (w_can_ins) begin
                        w_next_req.we    = 1'b1;
                        w_next_req.waddr = w_addr;
                        w_next_req.wdata = r_head;
                        w_prev_req.we    = 1'b1;
                        w_prev_req.waddr = w_addr;
                        w_prev_req.wdata = '0;
                        n_head           = w_addr;
                        n_len            = r_len + LW'(1);
                        if (w_len_zero) begin
                            n_tail = w_addr;
                        end else begin
                            n_at    = r_head;
                            n_state = S_FIXP;
                        end
                    end
                end
                dllm_pkg::REQ_PUSH_BACK, dllm_pkg::REQ_INSERT_MID: begin
                    if (w_can_ins) begin
                        n_len = r_len + LW'(1);
                        if (i_in_req == dllm_pkg::REQ_INSERT_MID &&
                            r_len > LW'(1)) begin
                            // walk len/2-1 links from the head
                            n_at             = r_head;
                            w_next_req.raddr = r_head;
                            n_cnt            = (r_len >> 1) - LW'(1);
                            n_state          = S_WALK;
                        end else begin
                            // short list: middle insert is a back push
                            w_next_req.we    = 1'b1;
                            w_next_req.waddr = w_addr;
                            w_next_req.wdata = '0;
                            w_prev_req.we    = 1'b1;
                            w_prev_req.waddr = w_addr;
                            w_prev_req.wdata = r_tail;
                            n_tail           = w_addr;
                            if (w_len_zero) begin
                                n_head = w_addr;
                            end else begin
                                n_at    = r_tail;
                                n_state = S_FIXN;
                            end
                        end
                    end
                end
                dllm_pkg::REQ_POP_FRONT: begin
                    if (w_len_zero) begin
                        n_err = 1'b1;
                    end else begin
                        n_popped = r_head;
                        n_len    = r_len - LW'(1);
                        if (r_len != LW'(1)) begin
                            w_next_req.raddr = r_head;
                            n_state          = S_POPF;
                        end
                    end
                end
                dllm_pkg::REQ_POP_BACK: begin
                    if (w_len_zero) begin
                        n_err = 1'b1;
                    end else begin
                        n_popped = r_tail;
                        n_len    = r_len - LW'(1);
                        if (r_len != LW'(1)) begin
                            w_prev_req.raddr = r_tail;
                            n_state          = S_POPB;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_len   <= n_len;
        end
        r_node   <= n_node;
        r_at     <= n_at;
        r_after  <= n_after;
        r_cnt    <= n_cnt;
        r_popped <= n_popped;
        r_err    <= n_err;
    end

    assign o_res_valid    = w_emit;
    assign o_res.node_out = dllm_pkg::NODE_W'(r_popped);
    assign o_res.error    = r_err;
    assign o_res.count    = dllm_pkg::COUNT_W'(r_len);
    assign o_res.is_empty = w_len_zero;
    assign o_next_req     = w_next_req;
    assign o_prev_req     = w_prev_req;

endmodule

// File: design/doubly_linked_list_manager_unit.sv
// sequencing: push front/back and pops pass at most one link fix-up state before the result
//   state; middle insert walks links in S_WALK, one next-link memory read each, then S_LINK
// throughput: one request at a time; a new transfer is taken in the cycle the
//   previous result moves into the output register, so one result may wait there
// reset: synchronous active low, empties the list; link memories are not cleared
module doubly_linked_list_manager_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dllm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] node
    input  logic [dllm_pkg::REQ_W-1:0]        s_axis_tuser,  // [2:0] req_type
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] node_out, [8] error, [17:9] count, [18] is_empty, rest zero
    output logic [dllm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // link memory ports
    dllm_pkg::t_mem_req                next_req;
    dllm_pkg::t_mem_req                prev_req;
    logic [dllm_pkg::ADDR_W-1:0]       next_rdata;
    logic [dllm_pkg::ADDR_W-1:0]       prev_rdata;

    // sequencer result hand-off
    logic                              res_valid;
    dllm_pkg::t_result                 res;
    logic                              out_free;

    // output register
    logic                              r_out_valid, n_out_valid;
    dllm_pkg::t_result                 r_out;

    // successor links
    dllm_ram #(
        .DEPTH (dllm_pkg::NODES),
        .WIDTH (dllm_pkg::ADDR_W)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_req.we),
        .i_waddr (next_req.waddr),
        .i_wdata (next_req.wdata),
        .i_raddr (next_req.raddr),
        .o_rdata (next_rdata)
    );

    // predecessor links
    dllm_ram #(
        .DEPTH (dllm_pkg::NODES),
        .WIDTH (dllm_pkg::ADDR_W)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_req.we),
        .i_waddr (prev_req.waddr),
        .i_wdata (prev_req.wdata),
        .i_raddr (prev_req.raddr),
        .o_rdata (prev_rdata)
    );

    // accesses are sequenced so that a read never meets a write to the same
    // memory in one cycle, hence no forwarding path
    dllm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_req     (s_axis_tuser),
        .i_in_node    (dllm_pkg::NODE_W'(s_axis_tdata)),
        .o_in_ready   (s_axis_tready),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_next_req   (next_req),
        .o_prev_req   (prev_req),
        .i_next_rdata (next_rdata),
        .i_prev_rdata (prev_rdata)
    );

    // slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = dllm_pkg::OUT_DATA_W'(r_out);

endmodule

// File: design/dllm_checker.sv
// port-level checks of the linked list manager, bound to the top level
// depends on dllm_pkg and assert_macros.svh
`include "assert_macros.svh"

module dllm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [dllm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [dllm_pkg::REQ_W-1:0]        s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [dllm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    dllm_pkg::t_result                                  w_res;
    logic                                               w_out_wait;
    logic                                               w_in_wait;
    logic [dllm_pkg::REQ_W+dllm_pkg::IN_DATA_W-1:0]     w_in_word;
    logic                                               w_count_ok;
    logic                                               w_err_clean;

    assign w_res       = dllm_pkg::t_result'(m_axis_tdata[dllm_pkg::RES_W-1:0]);
    assign w_out_wait  = m_axis_tvalid && !m_axis_tready;
    assign w_in_wait   = s_axis_tvalid && !s_axis_tready;
    assign w_in_word   = {s_axis_tuser, s_axis_tdata};
    assign w_count_ok  = (int'(w_res.count) <= dllm_pkg::NODES) &&
                         (w_res.is_empty == (w_res.count == '0));
    assign w_err_clean = w_res.is_empty && (w_res.node_out == '0);

    // stalled result holds
    `DLLM_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_wait |=> m_axis_tvalid && $stable(m_axis_tdata))

    // offered request holds until its transfer
    `DLLM_ASSERT(a_in_hold, i_clk, i_rst_n, w_in_wait |=> s_axis_tvalid && $stable(w_in_word))

    // count within capacity and empty flag agrees with it
    `DLLM_ASSERT(a_count_ok, i_clk, i_rst_n, m_axis_tvalid |-> w_count_ok)

    // a failed pop leaves an empty list and returns no handle
    `DLLM_ASSERT(a_err_empty, i_clk, i_rst_n, m_axis_tvalid && w_res.error |-> w_err_clean)

    // no result straight out of reset
    `DLLM_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind doubly_linked_list_manager_unit dllm_checker u_dllm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/dllm_reply_checker.sv
// reply checker for the linked list manager: predicts every reply and compares it
// depends on dllm_pkg for widths, request codes and the result layout
`timescale 1ns / 1ps

module dllm_reply_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_tvalid,
    input  logic                            i_req_tready,
    input  logic [dllm_pkg::IN_DATA_W-1:0]  i_req_tdata,   // [7:0] node
    input  logic [dllm_pkg::REQ_W-1:0]      i_req_tuser,   // [2:0] req_type
    input  logic                            i_rsp_tvalid,
    input  logic                            i_rsp_tready,
    // [7:0] node_out, [8] error, [17:9] count, [18] is_empty
    input  logic [dllm_pkg::OUT_DATA_W-1:0] i_rsp_tdata,
    output int                              o_mismatches,
    output int                              o_pending
);
    import dllm_pkg::*;

    logic [NODE_W-1:0]  next_of [NODES];
    logic [NODE_W-1:0]  prev_of [NODES];
    logic [NODE_W-1:0]  head_node;
    logic [NODE_W-1:0]  tail_node;
    logic [COUNT_W-1:0] list_len;
    t_result            pending_replies[$];
    int                 mismatch_count = 0;

    function automatic void link_back(input logic [NODE_W-1:0] h);
        next_of[h] = '0;
        prev_of[h] = tail_node;
        if (list_len == 0) begin
            head_node = h;
        end else begin
            next_of[tail_node] = h;
        end
        tail_node = h;
        list_len  = list_len + 1'b1;
    endfunction

    // applies one request to the list and returns the reply it gives
    function automatic t_result predict_reply(input logic [REQ_W-1:0] req,
                                              input logic [NODE_W-1:0] h);
        t_result           reply;
        logic [NODE_W-1:0] walk;
        logic [NODE_W-1:0] after;
        int                steps;
        bit                room;
        reply = '0;
        room  = (list_len < NODES) && (int'(h) < NODES);
        case (req)
            REQ_PUSH_FRONT: begin
                if (room) begin
                    next_of[h] = head_node;
                    prev_of[h] = '0;
                    if (list_len == 0) begin
                        tail_node = h;
                    end else begin
                        prev_of[head_node] = h;
                    end
                    head_node = h;
                    list_len  = list_len + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (room) link_back(h);
            end
            REQ_INSERT_MID: begin
                if (room && list_len == 0) begin
                    link_back(h);
                end else if (room) begin
                    // link after the element at max(len/2,1)-1
                    steps = (list_len < 2) ? 0 : int'(list_len) / 2 - 1;
                    walk  = head_node;
                    repeat (steps) walk = next_of[walk];
                    if (steps == int'(list_len) - 1) begin
                        next_of[h]    = '0;
                        prev_of[h]    = walk;
                        next_of[walk] = h;
                        tail_node     = h;
                    end else begin
                        after          = next_of[walk];
                        prev_of[h]     = walk;
                        next_of[h]     = after;
                        next_of[walk]  = h;
                        prev_of[after] = h;
                    end
                    list_len = list_len + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (list_len == 0) begin
                    reply.error = 1'b1;
                end else begin
                    reply.node_out = head_node;
                    list_len       = list_len - 1'b1;
                    if (list_len != 0) begin
                        head_node          = next_of[reply.node_out];
                        prev_of[head_node] = '0;
                    end
                end
            end
            REQ_POP_BACK: begin
                if (list_len == 0) begin
                    reply.error = 1'b1;
                end else begin
                    reply.node_out = tail_node;
                    list_len       = list_len - 1'b1;
                    if (list_len != 0) begin
                        tail_node          = prev_of[reply.node_out];
                        next_of[tail_node] = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        reply.count    = list_len;
        reply.is_empty = (list_len == 0);
        return reply;
    endfunction

    always @(posedge i_clk) begin : check_replies
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            head_node = '0;
            tail_node = '0;
            list_len  = '0;
            pending_replies.delete();
        end else begin
            if (i_rsp_tvalid && i_rsp_tready) begin
                got = t_result'(i_rsp_tdata[RES_W-1:0]);
                if (pending_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("reply with nothing outstanding: node %0d err %0d count %0d empty %0d",
                                 got.node_out, got.error, got.count, got.is_empty);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.node_out !== want.node_out || got.error !== want.error ||
                        got.count !== want.count || got.is_empty !== want.is_empty) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"reply mismatch: expected node %0d err %0d count %0d ",
                                      "empty %0d, got node %0d err %0d count %0d empty %0d"},
                                     want.node_out, want.error, want.count, want.is_empty,
                                     got.node_out, got.error, got.count, got.is_empty);
                    end
                end
            end
            if (i_req_tvalid && i_req_tready)
                pending_replies.push_back(predict_reply(i_req_tuser, i_req_tdata[NODE_W-1:0]));
        end
        o_pending    <= pending_replies.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: test/tb_doubly_linked_list_manager_unit.sv
// top of the linked list manager testbench: clock, reset, request and reply traffic, verdict
// depends on dllm_pkg, doubly_linked_list_manager_unit and dllm_reply_checker
`timescale 1ns / 1ps

module tb_doubly_linked_list_manager_unit;
    import dllm_pkg::*;

    localparam int ITEMS          = 800;   // rough size of the whole run
    localparam int QUIET_ITEMS    = 100;   // closing stretch with no idling
    localparam int HOLD_AT        = 40;    // request count that triggers the long hold
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int SETTLE_CYCLES  = 20;

    // spare request codes, the block treats them as a query
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] node
    logic [REQ_W-1:0]      s_axis_tuser  = '0;   // [2:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] node_out, [8] error, [17:9] count, [18] is_empty, rest zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;
    int idle_cycles = 0;

    // stimulus progress, shared with the reply side
    int issued    = 0;
    bit quiet     = 1'b0;
    bit holding   = 1'b0;
    bit hold_done = 1'b0;

    // order of the handles as the block will hold them, so no linked handle
    // is ever inserted again
    logic [NODE_W-1:0] members[$];
    bit                linked [NODES];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    doubly_linked_list_manager_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dllm_reply_checker reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_tvalid (s_axis_tvalid),
        .i_req_tready (s_axis_tready),
        .i_req_tdata  (s_axis_tdata),
        .i_req_tuser  (s_axis_tuser),
        .i_rsp_tvalid (m_axis_tvalid),
        .i_rsp_tready (m_axis_tready),
        .i_rsp_tdata  (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // a handle not in the list, searched upwards from a random start;
    // only called while the list has room
    function automatic logic [NODE_W-1:0] free_handle();
        logic [NODE_W-1:0] h;
        h = NODE_W'($urandom_range(0, NODES - 1));
        while (linked[h]) h = h + 1'b1;
        return h;
    endfunction

    // updates the handle order, then offers one request and waits for its transfer
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [NODE_W-1:0] h);
        int len;
        int gap;
        len = members.size();
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT_MID: begin
                if (len < NODES) begin
                    linked[h] = 1'b1;
                    if (req == REQ_PUSH_FRONT) begin
                        members.push_front(h);
                    end else if (req == REQ_PUSH_BACK) begin
                        members.push_back(h);
                    end else begin
                        // lands just after position max(len/2,1)-1
                        members.insert((len < 2) ? len : len / 2, h);
                    end
                end
            end
            REQ_POP_FRONT: begin
                if (len > 0) linked[members.pop_front()] = 1'b0;
            end
            REQ_POP_BACK: begin
                if (len > 0) linked[members.pop_back()] = 1'b0;
            end
            default: begin
            end
        endcase
        issued++;
        quiet = (issued > ITEMS - QUIET_ITEMS);

        @(negedge i_clk);
        // no gaps while the receiver holds off, so the block backs up
        if (!quiet && !holding && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(h);
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // one random request; grow_pct is the share of inserts
    task automatic send_random(input int grow_pct);
        logic [REQ_W-1:0]  req;
        logic [NODE_W-1:0] h;
        int                roll;
        roll = $urandom_range(0, 99);
        h    = NODE_W'($urandom());
        if (roll < grow_pct) begin
            case ($urandom_range(0, 2))
                0:       req = REQ_PUSH_FRONT;
                1:       req = REQ_PUSH_BACK;
                default: req = REQ_INSERT_MID;
            endcase
            // a full list ignores the insert, so any handle will do there
            if (members.size() < NODES) h = free_handle();
        end else if (roll < 92) begin
            req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
        end else begin
            case ($urandom_range(0, 2))
                0:       req = REQ_QUERY;
                1:       req = REQ_SPARE_6;
                default: req = REQ_SPARE_7;
            endcase
        end
        send_request(req, h);
    endtask

    // request side
    initial begin
        int grow;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list errors, middle insert into empty and one-element
        // lists, field extremes and every request code
        send_request(REQ_QUERY,      8'hA5);
        send_request(REQ_POP_FRONT,  8'hFF);
        send_request(REQ_POP_BACK,   8'h00);
        send_request(REQ_INSERT_MID, 8'h00);
        send_request(REQ_INSERT_MID, 8'hFF);
        send_request(REQ_PUSH_FRONT, 8'h55);
        send_request(REQ_PUSH_BACK,  8'hAA);
        send_request(REQ_INSERT_MID, 8'h01);
        send_request(REQ_INSERT_MID, 8'h80);
        send_request(REQ_SPARE_6,    8'h7F);
        send_request(REQ_SPARE_7,    8'hFE);
        send_request(REQ_POP_FRONT,  8'h00);
        send_request(REQ_POP_BACK,   8'hFF);
        send_request(REQ_POP_FRONT,  8'h3C);
        send_request(REQ_POP_BACK,   8'hC3);
        send_request(REQ_POP_FRONT,  8'h00);
        send_request(REQ_POP_BACK,   8'h00);
        send_request(REQ_POP_FRONT,  8'h00);
        send_request(REQ_PUSH_BACK,  8'h10);
        send_request(REQ_POP_FRONT,  8'h00);

        // balanced traffic around a short list
        repeat (40) send_random(50);

        // fill to capacity, offer inserts the full list must ignore, then drain
        while (members.size() < NODES) send_random(100);
        repeat (6) send_random(100);
        send_request(REQ_QUERY, 8'h00);
        while (members.size() > 0) send_random(0);
        send_request(REQ_POP_BACK, 8'h00);

        // phases that let the list grow, hover or shrink
        while (issued < ITEMS) begin
            case ($urandom_range(0, 2))
                0:       grow = 25;
                1:       grow = 50;
                default: grow = 75;
            endcase
            repeat (40) send_random(grow);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // reply side: short random stalls, one long hold, none in the closing stretch
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            if (!hold_done && issued >= HOLD_AT) begin
                hold_done = 1'b1;
                holding   = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holding = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// File: doubly_linked_list_manager_unit.f
+incdir+design
design/dllm_pkg.sv
design/dllm_ram.sv
design/dllm_ctrl.sv
design/doubly_linked_list_manager_unit.sv
design/dllm_checker.sv
test/dllm_reply_checker.sv
test/tb_doubly_linked_list_manager_unit.sv
